/* rtl/rme_pkg.sv */
// shared constants, types and state encoding for the rsa modular exponentiation block
package rme_pkg;

    localparam int WORD_BITS    = 20;
    localparam int BYTE_BITS    = 8;
    localparam int CNT_BITS     = $clog2(WORD_BITS);
    localparam int CFG_IDX_BITS = 2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam word_t EXP_RESET = WORD_BITS'(537653);
    localparam word_t MOD_RESET = WORD_BITS'(968087);

    localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = CFG_IDX_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } state_t;

endpackage

/* rtl/rsa_modular_exponentiation.sv */
// top level: cipher word to the configured exponent modulo the configured modulus
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_cipher_word
//  m_       out        m_valid / m_ready  m_plain_value, m_plain_byte
//  cfg_     in         cfg_wr_en          cfg_index, cfg_data (exponent = 0, modulus = 1)
//
// one item at a time through a shared bit-serial modular multiplier, one multiplier bit per cycle
// exponent zero or modulus below two: the result is known at once, without the multiplier
// synchronous active-low reset: idle, output empty, registers back to the built-in key
// a result waiting in the output register does not block the next transfer in; the block only
// holds in ST_DONE when its new result finds the output register still full
module rsa_modular_exponentiation (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rme_pkg::WORD_BITS-1:0]     s_cipher_word,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rme_pkg::WORD_BITS-1:0]     m_plain_value,
    output logic [rme_pkg::BYTE_BITS-1:0]     m_plain_byte,

    input  logic                              cfg_wr_en,
    input  logic [rme_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rme_pkg::WORD_BITS-1:0]     cfg_data
);

    // control state
    rme_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    rme_pkg::word_t  exp_reg, exp_next;
    rme_pkg::word_t  mod_reg, mod_next;

    // datapath registers
    rme_pkg::word_t  base_reg, base_next;       // reduced cipher word
    rme_pkg::word_t  mul_a_reg, mul_a_next;     // multiplier, scanned msb first
    rme_pkg::word_t  mul_b_reg, mul_b_next;     // multiplicand, below modulus
    rme_pkg::word_t  r_reg, r_next;             // running partial residue
    rme_pkg::cnt_t   cnt_reg, cnt_next;         // multiplier bit counter
    rme_pkg::cnt_t   idx_reg, idx_next;         // exponent bit being processed
    rme_pkg::word_t  res_reg, res_next;         // finished result, waiting for the output
    rme_pkg::word_t  out_reg, out_next;         // output register

    // shared modular multiplier step
    logic [rme_pkg::WORD_BITS:0] mod_ext;
    logic [rme_pkg::WORD_BITS:0] dbl;
    rme_pkg::word_t              dbl_red;
    logic [rme_pkg::WORD_BITS:0] add_sum;
    rme_pkg::word_t              product;
    logic                        mul_last;

    always_comb begin
        mod_ext = {1'b0, mod_reg};
        // r = 2r mod m, r < m keeps it below 2m
        dbl = {r_reg, 1'b0};
        if (dbl >= mod_ext) begin
            dbl_red = rme_pkg::WORD_BITS'(dbl - mod_ext);
        end else begin
            dbl_red = dbl[rme_pkg::WORD_BITS-1:0];
        end
        // r = r + b mod m when the current multiplier bit is set
        add_sum = {1'b0, dbl_red} +
                  {1'b0, (mul_a_reg[rme_pkg::WORD_BITS-1] ? mul_b_reg : '0)};
        if (add_sum >= mod_ext) begin
            product = rme_pkg::WORD_BITS'(add_sum - mod_ext);
        end else begin
            product = add_sum[rme_pkg::WORD_BITS-1:0];
        end
        mul_last = (cnt_reg == rme_pkg::CNT_BITS'(rme_pkg::WORD_BITS - 1));
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        exp_next     = exp_reg;
        mod_next     = mod_reg;
        base_next    = base_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        r_next       = r_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        out_next     = out_reg;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes, to be issued only while idle; the block itself does not enforce this
        if (cfg_wr_en) begin
            case (cfg_index)
                rme_pkg::REG_EXPONENT: exp_next = cfg_data;
                rme_pkg::REG_MODULUS:  mod_next = cfg_data;
                default: ;
            endcase
        end

        // multiplier advances one bit each busy cycle
        if (state_reg == rme_pkg::ST_REDUCE || state_reg == rme_pkg::ST_SQUARE ||
            state_reg == rme_pkg::ST_MULT) begin
            mul_a_next = {mul_a_reg[rme_pkg::WORD_BITS-2:0], 1'b0};
            r_next     = product;
            cnt_next   = cnt_reg + rme_pkg::CNT_BITS'(1);
        end

        case (state_reg)
            rme_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (exp_reg == '0) begin
                        // exponent zero: the unreduced starting value
                        res_next   = rme_pkg::WORD_BITS'(1);
                        state_next = rme_pkg::ST_DONE;
                    end else if (mod_reg < rme_pkg::WORD_BITS'(2)) begin
                        // degenerate modulus: every residue is taken as zero
                        res_next   = '0;
                        state_next = rme_pkg::ST_DONE;
                    end else begin
                        // reduce the cipher word as cipher * 1 mod m
                        mul_a_next = s_cipher_word;
                        mul_b_next = rme_pkg::WORD_BITS'(1);
                        r_next     = '0;
                        cnt_next   = '0;
                        state_next = rme_pkg::ST_REDUCE;
                    end
                end
            end
            rme_pkg::ST_REDUCE: begin
                if (mul_last) begin
                    base_next  = product;
                    // first square of the accumulator, which starts at one
                    mul_a_next = rme_pkg::WORD_BITS'(1);
                    mul_b_next = rme_pkg::WORD_BITS'(1);
                    r_next     = '0;
                    cnt_next   = '0;
                    idx_next   = rme_pkg::CNT_BITS'(rme_pkg::WORD_BITS - 1);
                    state_next = rme_pkg::ST_SQUARE;
                end
            end
            rme_pkg::ST_SQUARE: begin
                if (mul_last) begin
                    r_next   = '0;
                    cnt_next = '0;
                    if (exp_reg[idx_reg]) begin
                        mul_a_next = product;
                        mul_b_next = base_reg;
                        state_next = rme_pkg::ST_MULT;
                    end else if (idx_reg == '0) begin
                        res_next   = product;
                        state_next = rme_pkg::ST_DONE;
                    end else begin
                        idx_next   = idx_reg - rme_pkg::CNT_BITS'(1);
                        mul_a_next = product;
                        mul_b_next = product;
                    end
                end
            end
            rme_pkg::ST_MULT: begin
                if (mul_last) begin
                    r_next   = '0;
                    cnt_next = '0;
                    if (idx_reg == '0) begin
                        res_next   = product;
                        state_next = rme_pkg::ST_DONE;
                    end else begin
                        idx_next   = idx_reg - rme_pkg::CNT_BITS'(1);
                        mul_a_next = product;
                        mul_b_next = product;
                        state_next = rme_pkg::ST_SQUARE;
                    end
                end
            end
            rme_pkg::ST_DONE: begin
                // hand over once the output register is free or freeing
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = rme_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rme_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            exp_reg     <= rme_pkg::EXP_RESET;
            mod_reg     <= rme_pkg::MOD_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            exp_reg     <= exp_next;
            mod_reg     <= mod_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg  <= base_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        r_reg     <= r_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign s_ready       = (state_reg == rme_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_plain_value = out_reg;
    assign m_plain_byte  = out_reg[rme_pkg::BYTE_BITS-1:0];

endmodule

/* rtl/rme_checker.sv */
// port-level checks for the rsa modular exponentiation block, with its bind
module rme_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [rme_pkg::WORD_BITS-1:0]     m_plain_value,
    input logic [rme_pkg::BYTE_BITS-1:0]     m_plain_byte
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_plain_value))
        else $error("result changed while stalled");

    // character is the low byte of the residue
    a_byte_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_plain_byte == m_plain_value[rme_pkg::BYTE_BITS-1:0])
        else $error("plain byte does not match plain value");

    // busy right after an input transfer
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready again right after an input transfer");

    // reset leaves the block idle with an empty output
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_plain_value (m_plain_value),
    .m_plain_byte  (m_plain_byte)
);

/* tb/rsa_modular_exponentiation_test.sv */
// self-checking testbench for the rsa modular exponentiation block
module rsa_modular_exponentiation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rme_pkg::*;

    // register indexes that the block must ignore
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = CFG_IDX_BITS'(3);

    localparam word_t WORD_MAX = {WORD_BITS{1'b1}};

    // cycles with no transfer on either channel before the run is declared hung:
    // longest item plus longest sender gap, receiver stall and configuration pause,
    // taken several times over
    localparam int QUIET_LIMIT = 12000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 69;

    typedef struct packed {
        word_t                value;
        logic [BYTE_BITS-1:0] low_byte;
    } plain_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid = 1'b0;
    logic                    s_ready;
    word_t                   s_cipher_word = '0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    word_t                   m_plain_value;
    logic [BYTE_BITS-1:0]    m_plain_byte;

    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    word_t                   cfg_data = '0;

    // own copy of the key registers, starting from the built-in key
    word_t key_exponent = EXP_RESET;
    word_t key_modulus  = MOD_RESET;

    word_t  cipher_pending[$];   // cipher words not yet offered to the block
    plain_t plain_expected[$];   // predicted plaintext, oldest first

    int fail_count = 0;
    int quiet_cycles = 0;
    logic in_xfer = 1'b0;

    // sender and receiver pacing state
    int burst_left = 0;
    int gap_left = 0;
    int ready_run = 0;
    int stall_run = 0;

    rsa_modular_exponentiation uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cipher_word (s_cipher_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_plain_value (m_plain_value),
        .m_plain_byte  (m_plain_byte),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // square-and-multiply over every exponent bit, msb first
    function automatic plain_t decrypt_word(word_t cipher, word_t e, word_t m);
        logic [63:0] acc;
        logic [63:0] base;
        plain_t      p;
        // exponent zero: starting value is never reduced
        if (e == '0) begin
            acc = 64'd1;
        // modulus zero or one: every residue taken as zero
        end else if (m < word_t'(2)) begin
            acc = 64'd0;
        end else begin
            base = 64'(cipher) % 64'(m);
            acc = 64'd1;
            for (int i = WORD_BITS - 1; i >= 0; i--) begin
                acc = (acc * acc) % 64'(m);
                if (e[i]) begin
                    acc = (acc * base) % 64'(m);
                end
            end
        end
        p.value = word_t'(acc);
        p.low_byte = p.value[BYTE_BITS-1:0];
        return p;
    endfunction

    // cipher words biased toward the modulus boundary and the extremes
    function automatic word_t pick_cipher(word_t m);
        word_t w;
        case ($urandom_range(0, 9))
            6: begin
                w = (m == '0) ? word_t'($urandom) : word_t'($urandom_range(0, m - 1));
            end
            7: begin
                // just below, at and just above the modulus
                w = m + word_t'($urandom_range(0, 2)) - word_t'(1);
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: w = '0;
                    1: w = word_t'(1);
                    default: w = WORD_MAX;
                endcase
            end
            9: w = word_t'($urandom_range(0, 255));
            default: w = word_t'($urandom);
        endcase
        return w;
    endfunction

    // register write at the falling edge, taken by the block at the next rising edge
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_EXPONENT: key_exponent = data;
            REG_MODULUS:  key_modulus = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // block is idle once every word is sent and every plaintext has come back
    task automatic drain;
        while (cipher_pending.size() != 0 || s_valid || plain_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // driver: one word per transfer, bursts of random length with gaps between them
    always @(negedge aclk) begin
        logic  nxt_valid;
        word_t nxt_word;
        nxt_valid = 1'b0;
        nxt_word = s_cipher_word;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_xfer) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cipher_pending.size() != 0) begin
                nxt_word = cipher_pending.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // new burst, then a gap: often none, sometimes short, rarely long
                    burst_left = $urandom_range(0, 7);
                    case ($urandom_range(0, 9))
                        0, 1: gap_left = $urandom_range(10, 900);
                        2, 3, 4: gap_left = $urandom_range(1, 10);
                        default: gap_left = 0;
                    endcase
                end
            end
            s_valid <= nxt_valid;
            s_cipher_word <= nxt_word;
        end
    end

    // receiver: ready runs and stall runs of random length, with long stall-free stretches
    always @(negedge aclk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (ready_run > 0) begin
            ready_run--;
        end else if (stall_run > 0) begin
            stall_run--;
            nxt_ready = 1'b0;
        end else begin
            case ($urandom_range(0, 5))
                0: ready_run = 3000;
                1: stall_run = $urandom_range(20, 300);
                default: begin
                    ready_run = $urandom_range(0, 4);
                    stall_run = $urandom_range(0, 3);
                end
            endcase
        end
        m_ready <= nxt_ready;
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge aclk) begin
        plain_t want;
        logic   s_fire;
        logic   m_fire;
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        in_xfer <= s_fire;
        // check first so a result can never match the word sent in the same cycle
        if (m_fire) begin
            if (plain_expected.size() == 0) begin
                $display("%0t: unexpected result value %0d byte %0d",
                         $time, m_plain_value, m_plain_byte);
                fail_count++;
            end else begin
                want = plain_expected.pop_front();
                if (m_plain_value !== want.value) begin
                    $display("%0t: plain_value expected %0d actual %0d",
                             $time, want.value, m_plain_value);
                    fail_count++;
                end
                if (m_plain_byte !== want.low_byte) begin
                    $display("%0t: plain_byte expected %0d actual %0d",
                             $time, want.low_byte, m_plain_byte);
                    fail_count++;
                end
            end
        end
        if (s_fire) begin
            plain_expected.push_back(decrypt_word(s_cipher_word, key_exponent, key_modulus));
        end
        // watchdog on cycles with no transfer at all
        if (s_fire || m_fire || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        word_t e;
        word_t m;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // built-in key: extremes and the modulus boundary
        cipher_pending.push_back('0);
        cipher_pending.push_back(word_t'(1));
        cipher_pending.push_back(word_t'(2));
        cipher_pending.push_back(MOD_RESET - word_t'(1));
        cipher_pending.push_back(MOD_RESET);
        cipher_pending.push_back(MOD_RESET + word_t'(1));
        cipher_pending.push_back(WORD_MAX);
        cipher_pending.push_back(word_t'(20'h55555));
        cipher_pending.push_back(word_t'(20'hAAAAA));
        drain();

        // exponent zero gives one whatever the word
        write_reg(REG_EXPONENT, '0);
        write_reg(REG_MODULUS, WORD_MAX);
        cipher_pending.push_back('0);
        cipher_pending.push_back(WORD_MAX);
        cipher_pending.push_back(word_t'(12345));
        drain();

        // largest exponent with the smallest legal modulus
        write_reg(REG_EXPONENT, WORD_MAX);
        write_reg(REG_MODULUS, word_t'(2));
        cipher_pending.push_back('0);
        cipher_pending.push_back(word_t'(1));
        cipher_pending.push_back(WORD_MAX);
        drain();

        // modulus zero and one: residue taken as zero unless the exponent is zero
        write_reg(REG_EXPONENT, word_t'(7));
        write_reg(REG_MODULUS, '0);
        cipher_pending.push_back(word_t'(5));
        cipher_pending.push_back(WORD_MAX);
        drain();
        write_reg(REG_MODULUS, word_t'(1));
        cipher_pending.push_back(word_t'(9));
        drain();
        write_reg(REG_EXPONENT, '0);
        cipher_pending.push_back(word_t'(3));
        drain();

        // exponent one with the largest modulus, then writes to unused indexes
        write_reg(REG_EXPONENT, word_t'(1));
        write_reg(REG_MODULUS, WORD_MAX);
        write_reg(REG_SPARE_LO, '0);
        write_reg(REG_SPARE_HI, word_t'($urandom));
        cipher_pending.push_back(WORD_MAX);
        cipher_pending.push_back(WORD_MAX - word_t'(1));
        drain();

        // random keys, each phase with its own register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0: e = '0;
                1: e = word_t'(1);
                2: e = WORD_MAX;
                default: e = word_t'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: m = word_t'($urandom_range(0, 1));
                1: m = word_t'($urandom_range(2, 255));
                2: m = ($urandom_range(0, 1) != 0) ? WORD_MAX : word_t'(2);
                default: m = word_t'($urandom_range(2, WORD_MAX));
            endcase
            if ($urandom_range(0, 1) != 0) begin
                write_reg(REG_EXPONENT, e);
                write_reg(REG_MODULUS, m);
            end else begin
                write_reg(REG_MODULUS, m);
                write_reg(REG_EXPONENT, e);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, word_t'($urandom));
            for (int k = 0; k < PHASE_ITEMS; k++)
                cipher_pending.push_back(pick_cipher(key_modulus));
            drain();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rme_pkg.sv
rtl/rsa_modular_exponentiation.sv
rtl/rme_checker.sv
tb/rsa_modular_exponentiation_test.sv
